// ===== rtl/cse_pkg.sv =====
// Shared widths, register codes and stage types of the Chebyshev series evaluator.
package cse_pkg;

  localparam int X_W        = 16;
  localparam int SCALE_W    = 32;
  localparam int TERMS_W    = 3;
  localparam int COEF_W     = 16;
  localparam int T_W        = 16;
  localparam int RES_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_REGS  = 5;
  localparam int V_ONE      = 16384;
  localparam int SCALE_SHIFT = 16;
  localparam int REC_SHIFT  = 13;
  localparam int ONE_SHIFT  = 26;
  localparam int ACC_SHIFT  = 10;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER,
    REG_SCALE,
    REG_TERMS,
    REG_COEF1,
    REG_COEF2,
    REG_COEF3,
    REG_COEF4,
    REG_COEF5
  } cfg_reg_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic signed [T_W-1:0] v;
    logic signed [T_W-1:0] tprev;
    logic signed [T_W-1:0] tcur;
    logic                  sat;
  } cheb_t;

endpackage

// ===== rtl/cse_in_if.sv =====
// Sample channel of the Chebyshev series evaluator.
interface cse_in_if import cse_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_sample;

  modport source (output valid, output x_sample, input ready);
  modport sink (input valid, input x_sample, output ready);
endinterface

// ===== rtl/cse_out_if.sv =====
// Result channel of the Chebyshev series evaluator.
interface cse_out_if import cse_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] series_value;
  logic                    saturated;

  modport source (output valid, output series_value, output saturated, input ready);
  modport sink (input valid, input series_value, input saturated, output ready);
endinterface

// ===== rtl/cse_map.sv =====
// Three-stage front end that maps a sample onto the clamped Q2.14 coordinate.
module cse_map import cse_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [X_W-1:0]     x_sample,
  input  logic signed [X_W-1:0]     center,
  input  logic [SCALE_W-1:0]        scale,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cheb_t                     out_data
);

  localparam int D_W    = X_W + 1;
  localparam int PROD_W = D_W + SCALE_W + 1;
  localparam int SH_W   = PROD_W - SCALE_SHIFT;

  logic [2:0]               vld;
  logic [2:0]               rdy;
  logic signed [D_W-1:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SH_W-1:0]   shifted;
  logic signed [T_W-1:0]    v_clamped;
  logic                     v_hit;

  assign rdy[2]    = !vld[2] || out_ready;
  assign rdy[1]    = !vld[1] || rdy[2];
  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[2];

  assign shifted = $signed(prod[PROD_W-1:SCALE_SHIFT]);

  always_comb begin
    v_hit = 1'b0;
    v_clamped = T_W'(shifted);
    if (shifted > SH_W'(V_ONE)) begin
      v_hit = 1'b1;
      v_clamped = T_W'(V_ONE);
    end else if (shifted < -SH_W'(V_ONE)) begin
      v_hit = 1'b1;
      v_clamped = -T_W'(V_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) diff <= D_W'(x_sample) - D_W'(center);
    if (rdy[1]) prod <= diff * $signed({1'b0, scale});
    if (rdy[2]) begin
      out_data.v     <= v_clamped;
      out_data.tprev <= T_W'(V_ONE);
      out_data.tcur  <= v_clamped;
      out_data.sat   <= v_hit;
    end
  end

endmodule

// ===== rtl/cse_cell.sv =====
// One cell of the chain: adds one weighted term when its order is within the term count, and steps the recurrence.
module cse_cell import cse_pkg::*; #(
  parameter int ORDER = 1,
  parameter int ACC_W = 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cheb_t                   in_data,
  input  logic signed [ACC_W-1:0] in_acc,
  input  coef_t                   coef,
  input  logic [TERMS_W-1:0]      n_terms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cheb_t                   out_data,
  output logic signed [ACC_W-1:0] out_acc
);

  localparam int P_W   = T_W + COEF_W;
  localparam int VT_W  = 2 * T_W;
  localparam int REC_W = VT_W - REC_SHIFT + 1;

  logic                    valid;
  logic signed [P_W-1:0]   term;
  logic signed [VT_W-1:0]  vt;
  logic signed [REC_W-1:0] rec;
  logic signed [T_W-1:0]   tnext;
  logic                    active;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  assign term   = in_data.tcur * coef;
  assign vt     = in_data.v * in_data.tcur;
  assign rec    = REC_W'($signed(vt[VT_W-1:REC_SHIFT])) - REC_W'(in_data.tprev);
  assign active = n_terms >= TERMS_W'(ORDER);

  always_comb begin
    tnext = T_W'(rec);
    if (rec > REC_W'(V_ONE)) begin
      tnext = T_W'(V_ONE);
    end else if (rec < -REC_W'(V_ONE)) begin
      tnext = -T_W'(V_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data.v     <= in_data.v;
      out_data.tprev <= in_data.tcur;
      out_data.tcur  <= tnext;
      out_data.sat   <= in_data.sat;
      out_acc        <= active ? in_acc + ACC_W'(term) : in_acc;
    end
  end

endmodule

// ===== rtl/cse_out.sv =====
// Output stage that rescales the sum to Q16.16, saturates it and holds the result.
module cse_out import cse_pkg::*; #(
  parameter int ACC_W = 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ACC_W-1:0] in_acc,
  input  logic                    in_sat,
  cse_out_if.source               result
);

  localparam int SH_W  = ACC_W - ACC_SHIFT;
  localparam int CMP_W = (SH_W > RES_W + 1) ? SH_W : RES_W + 1;
  localparam logic signed [CMP_W-1:0] RES_MAX = CMP_W'({1'b0, {(RES_W - 1){1'b1}}});
  localparam logic signed [CMP_W-1:0] RES_MIN = -RES_MAX - CMP_W'(1);

  logic                    valid;
  logic signed [CMP_W-1:0] wide;
  logic signed [RES_W-1:0] value;
  logic                    clip;

  assign in_ready     = !valid || result.ready;
  assign result.valid = valid;
  assign wide         = CMP_W'($signed(in_acc[ACC_W-1:ACC_SHIFT]));

  always_comb begin
    clip = 1'b0;
    value = RES_W'(wide);
    if (wide > RES_MAX) begin
      clip = 1'b1;
      value = RES_W'(RES_MAX);
    end else if (wide < RES_MIN) begin
      clip = 1'b1;
      value = RES_W'(RES_MIN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      result.series_value <= value;
      result.saturated    <= in_sat || clip;
    end
  end

endmodule

// ===== rtl/chebyshev_series_evaluator.sv =====
// Chebyshev series evaluator: 1 + sum of c_k * T_k(v) over a stream of samples.
// Each sample is mapped to v = ((x - range_center) * range_scale) >>> 16 in Q2.14,
// clamped to +/-1, and the series is evaluated by a chain of cells, one per
// coefficient order, each adding its weighted term and stepping the recurrence.
// A new sample is accepted every cycle unless the chain stalls; a sample's result
// appears after 4 + min(MAX_TERMS, 5) register stages (three mapping stages, the
// cell chain and the output register), and a stage holds only where it is full
// and the one after it cannot move. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and must stay constant while samples
// are in flight. There is no clearing pass after reset.
module chebyshev_series_evaluator import cse_pkg::*; #(
  parameter int MAX_TERMS = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  cse_in_if.sink               sample,
  cse_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NC    = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;
  localparam int ACC_W = 31 + $clog2(NC + 1);
  localparam logic [TERMS_W-1:0]      NC_L    = TERMS_W'(NC);
  localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1) << ONE_SHIFT;

  logic signed [X_W-1:0]   range_center;
  logic [SCALE_W-1:0]      range_scale;
  logic [TERMS_W-1:0]      term_count;
  coef_t                   coef [COEF_REGS];
  logic [TERMS_W-1:0]      n_eff;

  cheb_t                   ch   [NC + 1];
  logic signed [ACC_W-1:0] acc  [NC + 1];
  logic                    vld  [NC + 1];
  logic                    rdy  [NC + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_center <= '0;
      range_scale  <= SCALE_RESET;
      term_count   <= '0;
      for (int i = 0; i < COEF_REGS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER: range_center <= cfg_data[X_W-1:0];
        REG_SCALE:  range_scale  <= cfg_data[SCALE_W-1:0];
        REG_TERMS:  term_count   <= cfg_data[TERMS_W-1:0];
        REG_COEF1:  coef[0]      <= cfg_data[COEF_W-1:0];
        REG_COEF2:  coef[1]      <= cfg_data[COEF_W-1:0];
        REG_COEF3:  coef[2]      <= cfg_data[COEF_W-1:0];
        REG_COEF4:  coef[3]      <= cfg_data[COEF_W-1:0];
        REG_COEF5:  coef[4]      <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff  = (term_count > NC_L) ? NC_L : term_count;
  assign acc[0] = ACC_ONE;

  cse_map u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .x_sample  (sample.x_sample),
    .center    (range_center),
    .scale     (range_scale),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (ch[0])
  );

  for (genvar k = 1; k <= NC; k++) begin : g_cell
    cse_cell #(
      .ORDER (k),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k-1]),
      .in_ready  (rdy[k-1]),
      .in_data   (ch[k-1]),
      .in_acc    (acc[k-1]),
      .coef      (coef[k-1]),
      .n_terms   (n_eff),
      .out_valid (vld[k]),
      .out_ready (rdy[k]),
      .out_data  (ch[k]),
      .out_acc   (acc[k])
    );
  end

  cse_out #(
    .ACC_W (ACC_W)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NC]),
    .in_ready (rdy[NC]),
    .in_acc   (acc[NC]),
    .in_sat   (ch[NC].sat),
    .result   (result)
  );

  // With the output register empty, every stage can move, so a sample is always taken.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("sample not taken while the result register is empty");

  // The mapped coordinate never leaves the clamp range.
  a_v_in_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (ch[0].v <= T_W'(V_ONE) && ch[0].v >= -T_W'(V_ONE)))
    else $error("mapped coordinate outside +/-1");

  // With no terms in use the series is exactly one.
  a_unit_series: assert property (@(posedge clk) disable iff (rst)
    (result.valid && term_count == '0) |-> result.series_value == RES_W'(1 << 16))
    else $error("empty series does not evaluate to one");

endmodule
